// ===== rtl/core/slpst_pkg.sv =====
`timescale 1ns / 1ps

package slpst_pkg;

	localparam int SLOTS_DEF       = 16;
	localparam int SCOPES_DEF      = 8;
	localparam int KEY_WIDTH_DEF   = 32;
	localparam int VALUE_WIDTH_DEF = 32;

	localparam int HASH_SHIFT  = 4;
	localparam int FIELD_WIDTH = 32;

	typedef enum logic [1:0] {
		MODE_PUSH   = 2'd0,
		MODE_POP    = 2'd1,
		MODE_ADD    = 2'd2,
		MODE_LOOKUP = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		STAT_OK        = 3'd0,
		STAT_INSERTED  = 3'd1,
		STAT_PRESENT   = 3'd2,
		STAT_FOUND     = 3'd3,
		STAT_NOT_FOUND = 3'd4,
		STAT_FULL      = 3'd5,
		STAT_DEPTH     = 3'd6
	} status_t;

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_HASH  = 6'b000010,
		S_CLEAR = 6'b000100,
		S_RD    = 6'b001000,
		S_CHK   = 6'b010000,
		S_RESP  = 6'b100000
	} state_t;

	typedef struct packed {
		mode_t                  mode;
		logic [FIELD_WIDTH-1:0] key;
		logic [FIELD_WIDTH-1:0] entry_value;
	} req_word_t;

	typedef struct packed {
		status_t                status;
		logic [FIELD_WIDTH-1:0] found_value;
		logic [2:0]             found_level;
	} rsp_word_t;

	// stored width of a field, never wider than the word field
	function automatic int field_bits(input int w);
		return (w < FIELD_WIDTH) ? w : FIELD_WIDTH;
	endfunction

endpackage

// ===== rtl/core/slpst_ram.sv =====
`timescale 1ns / 1ps

module slpst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/core/slpst_hash.sv =====
`timescale 1ns / 1ps

module slpst_hash import slpst_pkg::*; #(
	parameter int SLOTS = SLOTS_DEF,
	parameter int KEY_WIDTH = KEY_WIDTH_DEF,
	localparam int KW = field_bits(KEY_WIDTH),
	localparam int IW = $clog2(SLOTS)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [KW-1:0] key,
	output logic          done,
	output logic [IW-1:0] home
);

	localparam int HW = KW - HASH_SHIFT;

	logic          done_q;
	logic [IW-1:0] home_q;

	if ((SLOTS & (SLOTS - 1)) == 0) begin : g_mask
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				done_q <= 1'b0;
			end else begin
				done_q <= start;
			end
		end

		always_ff @(posedge clk) begin
			if (start) begin
				home_q <= IW'(key >> HASH_SHIFT);
			end
		end
	end else begin : g_rem
		localparam int DG = 4;
		localparam int ND = (HW + DG - 1) / DG;
		localparam int PW = ND * DG;
		localparam int CW = $clog2(ND + 1);
		localparam int RW = IW + DG;
		localparam logic [RW-1:0] M8 = RW'(8 * SLOTS);
		localparam logic [RW-1:0] M4 = RW'(4 * SLOTS);
		localparam logic [RW-1:0] M2 = RW'(2 * SLOTS);
		localparam logic [RW-1:0] M1 = RW'(SLOTS);

		logic [PW-1:0] sh_q;
		logic [CW-1:0] cnt_q;
		logic          busy_q;
		logic [RW-1:0] part0;
		logic [RW-1:0] part1;
		logic [RW-1:0] part2;
		logic [RW-1:0] part3;
		logic [RW-1:0] part4;
		logic [IW-1:0] rem_nx;

		// four key bits a cycle, msb first; partial remainder stays below the slot count
		assign part0  = {home_q, sh_q[PW-1 -: DG]};
		assign part1  = (part0 >= M8) ? part0 - M8 : part0;
		assign part2  = (part1 >= M4) ? part1 - M4 : part1;
		assign part3  = (part2 >= M2) ? part2 - M2 : part2;
		assign part4  = (part3 >= M1) ? part3 - M1 : part3;
		assign rem_nx = IW'(part4);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				busy_q <= 1'b0;
				done_q <= 1'b0;
				cnt_q  <= '0;
			end else if (start) begin
				busy_q <= 1'b1;
				done_q <= 1'b0;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q  <= cnt_q + CW'(1);
				busy_q <= (cnt_q != CW'(ND - 1));
				done_q <= (cnt_q == CW'(ND - 1));
			end else begin
				done_q <= 1'b0;
			end
		end

		always_ff @(posedge clk) begin
			if (start) begin
				sh_q   <= PW'(key[KW-1:HASH_SHIFT]);
				home_q <= '0;
			end else if (busy_q) begin
				sh_q   <= sh_q << DG;
				home_q <= rem_nx;
			end
		end
	end

	assign done = done_q;
	assign home = home_q;

endmodule

// ===== rtl/core/scoped_linear_probe_symbol_table.sv =====
`timescale 1ns / 1ps
// channel | signals                      | word
// req     | req_valid, req_ready, req    | mode, key, entry_value
// rsp     | rsp_valid, rsp_ready, rsp    | status, found_value, found_level
//
// one word at a time; req_ready is high only while the sequencer is idle
// pop and error cases: respond and return to idle; push: clears the new scope first
// add / lookup: hash (a registered mask, or a digit-serial remainder for a slot count
// not a power of two), then a read and a check per probe on the single table port,
// over every scope searched, then respond and return to idle
// reset clears control only; no sweep after reset, slot flags are cleared on push
// a waiting rsp word does not stop the next req word; it stalls only the next result

module scoped_linear_probe_symbol_table import slpst_pkg::*; #(
	parameter int SLOTS = SLOTS_DEF,
	parameter int SCOPES = SCOPES_DEF,
	parameter int KEY_WIDTH = KEY_WIDTH_DEF,
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  req_word_t req,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	output rsp_word_t rsp
);

	localparam int KW    = field_bits(KEY_WIDTH);
	localparam int VW    = field_bits(VALUE_WIDTH);
	localparam int IW    = $clog2(SLOTS);
	localparam int DEPTH = SCOPES * SLOTS;
	localparam int AW    = $clog2(DEPTH);
	localparam int OW    = $clog2(SCOPES + 1);
	localparam int SW    = (SCOPES > 1) ? $clog2(SCOPES) : 1;
	localparam int EW    = 1 + KW + VW;

	state_t        state_q;
	mode_t         op_q;
	logic [KW-1:0] key_q;
	logic [VW-1:0] val_q;
	logic [OW-1:0] open_q;
	logic [SW-1:0] scope_q;
	logic [AW-1:0] base_q;
	logic [IW-1:0] idx_q;
	logic [IW-1:0] home_q;
	logic [IW-1:0] cnt_q;
	rsp_word_t     res_q;
	rsp_word_t     rsp_q;
	logic          rsp_valid_q;

	logic          req_fire;
	logic          hash_start;
	logic          hash_done;
	logic [IW-1:0] hash_home;
	logic          ram_we;
	logic [AW-1:0] ram_addr;
	logic [EW-1:0] ram_wdata;
	logic [EW-1:0] ram_rdata;
	logic          rd_used;
	logic [KW-1:0] rd_key;
	logic [VW-1:0] rd_val;
	logic          is_add;
	logic          last_probe;
	logic [IW-1:0] idx_nx;
	status_t       first_status;

	assign req_ready = (state_q == S_IDLE);
	assign req_fire  = req_valid && req_ready;
	assign hash_start = req_fire && (open_q != '0)
		&& ((req.mode == MODE_ADD) || (req.mode == MODE_LOOKUP));

	assign rd_used = ram_rdata[EW-1];
	assign rd_key  = ram_rdata[EW-2 -: KW];
	assign rd_val  = ram_rdata[VW-1:0];

	assign is_add     = (op_q == MODE_ADD);
	assign last_probe = (cnt_q == IW'(SLOTS - 1));
	assign idx_nx     = (idx_q == IW'(SLOTS - 1)) ? '0 : idx_q + IW'(1);

	assign ram_addr  = base_q + AW'(idx_q);
	assign ram_we    = (state_q == S_CLEAR) || ((state_q == S_CHK) && is_add && !rd_used);
	assign ram_wdata = (state_q == S_CLEAR) ? '0 : {1'b1, key_q, val_q};

	always_comb begin
		unique case (req.mode)
			MODE_PUSH:          first_status = (open_q == OW'(SCOPES)) ? STAT_DEPTH : STAT_OK;
			MODE_POP, MODE_ADD: first_status = (open_q == '0) ? STAT_DEPTH : STAT_OK;
			MODE_LOOKUP:        first_status = STAT_NOT_FOUND;
			default:            first_status = STAT_DEPTH;
		endcase
	end

	slpst_hash #(
		.SLOTS(SLOTS),
		.KEY_WIDTH(KEY_WIDTH)
	) u_hash (
		.clk(clk),
		.arst_n(arst_n),
		.start(hash_start),
		.key(KW'(req.key)),
		.done(hash_done),
		.home(hash_home)
	);

	slpst_ram #(
		.WIDTH(EW),
		.DEPTH(DEPTH)
	) u_table (
		.clk(clk),
		.we(ram_we),
		.addr(ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			open_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if ((state_q == S_RESP) && (!rsp_valid_q || rsp_ready)) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_fire) begin
						unique case (req.mode)
							MODE_PUSH: begin
								if (open_q == OW'(SCOPES)) begin
									state_q <= S_RESP;
								end else begin
									state_q <= S_CLEAR;
								end
							end
							MODE_POP: begin
								if (open_q != '0) begin
									open_q <= open_q - OW'(1);
								end
								state_q <= S_RESP;
							end
							MODE_ADD, MODE_LOOKUP: begin
								if (open_q == '0) begin
									state_q <= S_RESP;
								end else begin
									state_q <= S_HASH;
								end
							end
							default: state_q <= S_RESP;
						endcase
					end
				end
				S_HASH: begin
					if (hash_done) begin
						state_q <= S_RD;
					end
				end
				S_CLEAR: begin
					if (idx_q == IW'(SLOTS - 1)) begin
						open_q  <= open_q + OW'(1);
						state_q <= S_RESP;
					end
				end
				S_RD: begin
					state_q <= S_CHK;
				end
				S_CHK: begin
					if (!rd_used || (rd_key == key_q)) begin
						state_q <= (is_add || rd_used) ? S_RESP : ((scope_q == '0) ? S_RESP : S_RD);
					end else if (last_probe) begin
						state_q <= (is_add || (scope_q == '0)) ? S_RESP : S_RD;
					end else begin
						state_q <= S_RD;
					end
				end
				S_RESP: begin
					if (!rsp_valid_q || rsp_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (req_fire) begin
					op_q    <= req.mode;
					key_q   <= KW'(req.key);
					val_q   <= VW'(req.entry_value);
					scope_q <= SW'(open_q - OW'(1));
					base_q  <= AW'(AW'(open_q) * AW'(SLOTS));
					idx_q   <= '0;
					res_q   <= '{status: first_status, found_value: '0, found_level: '0};
				end
			end
			S_HASH: begin
				if (hash_done) begin
					idx_q  <= hash_home;
					home_q <= hash_home;
					cnt_q  <= '0;
					base_q <= AW'(AW'(scope_q) * AW'(SLOTS));
				end
			end
			S_CLEAR: begin
				idx_q <= idx_nx;
			end
			S_CHK: begin
				if (rd_used && (rd_key == key_q)) begin
					if (is_add) begin
						res_q.status <= STAT_PRESENT;
					end else begin
						res_q.status      <= STAT_FOUND;
						res_q.found_value <= FIELD_WIDTH'(rd_val);
						res_q.found_level <= 3'(scope_q);
					end
				end else if (!rd_used && is_add) begin
					res_q.status <= STAT_INSERTED;
				end else if (!rd_used || last_probe) begin
					if (is_add) begin
						res_q.status <= STAT_FULL;
					end else begin
						// miss in this scope, move one scope outward
						scope_q <= scope_q - SW'(1);
						base_q  <= base_q - AW'(SLOTS);
						idx_q   <= home_q;
						cnt_q   <= '0;
					end
				end else begin
					idx_q <= idx_nx;
					cnt_q <= cnt_q + IW'(1);
				end
			end
			S_RESP: begin
				if (!rsp_valid_q || rsp_ready) begin
					rsp_q <= res_q;
				end
			end
			default: ;
		endcase
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef SYNTH
	a_open_bound: assert property (@(posedge clk) disable iff (!arst_n)
		open_q <= OW'(SCOPES))
		else $error("open scope count beyond stack depth");

	a_pop_step: assert property (@(posedge clk) disable iff (!arst_n)
		req_fire && (req.mode == MODE_POP) && (open_q != '0)
		|=> open_q == $past(open_q) - OW'(1))
		else $error("pop did not close exactly one scope");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status != STAT_FOUND)
		|-> (rsp.found_value == '0) && (rsp.found_level == '0))
		else $error("value or level set on a result that is not a hit");

	a_write_scope: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (open_q != '0) || (state_q == S_CLEAR))
		else $error("table written with no scope open");
`endif

endmodule

// ===== tb/tb_scoped_linear_probe_symbol_table.sv =====
`timescale 1ns / 1ps

module tb_scoped_linear_probe_symbol_table;
	import slpst_pkg::*;

	localparam int SLOT_N    = SLOTS_DEF;
	localparam int SCOPE_N   = SCOPES_DEF;
	localparam int POOL_N    = 32;
	localparam int RAND_N    = 1050;
	localparam int HOLD_AT   = 400;
	localparam int HOLD_LEN  = 300;
	localparam int TAIL_WAIT = 300;

	logic      clk;
	logic      arst_n = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_ready;
	req_word_t req = '0;
	logic      rsp_valid;
	logic      rsp_ready = 1'b0;
	rsp_word_t rsp;

	scoped_linear_probe_symbol_table dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	// shadow copy of the scope stack
	bit          tbl_used [SCOPE_N][SLOT_N];
	logic [31:0] tbl_key  [SCOPE_N][SLOT_N];
	logic [31:0] tbl_val  [SCOPE_N][SLOT_N];
	int          depth = 0;

	req_word_t   pending_req[$];
	rsp_word_t   expected_rsp[$];
	logic [31:0] pool [POOL_N];
	int          gen_depth = 0;
	int          req_sent = 0;
	int          rsp_seen = 0;
	int          feed_gap = 0;
	int          drain_wait = 0;
	int          hold_left = 0;
	int          mismatches = 0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic int draw_gap(input int count);
		// every fourth stretch of 64 words runs with no idling
		return (((count >> 6) % 4) == 1) ? 0 : int'($urandom_range(0, 8));
	endfunction

	function automatic bit probe_scope(input int s, input logic [31:0] k, output int pos,
			output bit hole);
		int idx;
		idx = int'((k >> HASH_SHIFT) % 32'(SLOT_N));
		pos = 0;
		hole = 1'b0;
		for (int n = 0; n < SLOT_N; n++) begin
			if (!tbl_used[s][idx]) begin
				pos = idx;
				hole = 1'b1;
				return 1'b0;
			end
			if (tbl_key[s][idx] == k) begin
				pos = idx;
				return 1'b1;
			end
			idx = (idx + 1) % SLOT_N;
		end
		return 1'b0;
	endfunction

	function automatic rsp_word_t table_step(input req_word_t w);
		rsp_word_t r;
		int pos;
		bit hole;
		int s;
		r = '0;
		r.status = STAT_OK;
		case (w.mode)
			MODE_PUSH: begin
				if (depth >= SCOPE_N) begin
					r.status = STAT_DEPTH;
				end else begin
					for (int i = 0; i < SLOT_N; i++) tbl_used[depth][i] = 1'b0;
					depth++;
				end
			end
			MODE_POP: begin
				if (depth == 0) begin
					r.status = STAT_DEPTH;
				end else begin
					depth--;
					for (int i = 0; i < SLOT_N; i++) tbl_used[depth][i] = 1'b0;
				end
			end
			MODE_ADD: begin
				if (depth == 0) begin
					r.status = STAT_DEPTH;
				end else begin
					s = depth - 1;
					if (probe_scope(s, w.key, pos, hole)) begin
						r.status = STAT_PRESENT;
					end else if (hole) begin
						tbl_used[s][pos] = 1'b1;
						tbl_key[s][pos] = w.key;
						tbl_val[s][pos] = w.entry_value;
						r.status = STAT_INSERTED;
					end else begin
						r.status = STAT_FULL;
					end
				end
			end
			default: begin
				r.status = STAT_NOT_FOUND;
				for (s = depth - 1; s >= 0; s--) begin
					if (probe_scope(s, w.key, pos, hole)) begin
						r.status = STAT_FOUND;
						r.found_value = tbl_val[s][pos];
						r.found_level = s[2:0];
						break;
					end
				end
			end
		endcase
		return r;
	endfunction

	task automatic queue_word(input mode_t m, input logic [31:0] k, input logic [31:0] v);
		req_word_t w;
		w.mode = m;
		w.key = k;
		w.entry_value = v;
		pending_req.push_back(w);
		if (m == MODE_PUSH && gen_depth < SCOPE_N) gen_depth++;
		if (m == MODE_POP && gen_depth > 0) gen_depth--;
	endtask

	task automatic flag_mismatch(input string what, input rsp_word_t want, input rsp_word_t got);
		mismatches++;
		if (mismatches <= 10)
			$display("%s: expected status %0d value %h level %0d, got status %0d value %h level %0d",
				what, want.status, want.found_value, want.found_level,
				got.status, got.found_value, got.found_level);
	endtask

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && req_ready) req_sent++;
			if (!(req_valid && !req_ready)) begin
				if (feed_gap > 0) begin
					feed_gap--;
					req_valid <= 1'b0;
				end else if (pending_req.size() > 0) begin
					req <= pending_req.pop_front();
					req_valid <= 1'b1;
					feed_gap = draw_gap(req_sent);
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// monitor and receiver
	always @(posedge clk) begin
		rsp_word_t want;
		if (arst_n) begin
			if (rsp_valid && rsp_ready) begin
				if (expected_rsp.size() == 0) begin
					flag_mismatch("unexpected word", '0, rsp);
				end else begin
					want = expected_rsp.pop_front();
					if (rsp.status !== want.status || rsp.found_value !== want.found_value
							|| rsp.found_level !== want.found_level)
						flag_mismatch("mismatch", want, rsp);
				end
				rsp_seen++;
				drain_wait = draw_gap(rsp_seen);
				if (rsp_seen == HOLD_AT) hold_left = HOLD_LEN;
			end
			if (req_valid && req_ready) expected_rsp.push_back(table_step(req));
			if (hold_left > 0) begin
				hold_left--;
				rsp_ready <= 1'b0;
			end else if (drain_wait > 0) begin
				drain_wait--;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	initial begin
		int target;
		int pick;
		int n;
		int base;
		bit first;
		logic [31:0] k;

		for (int i = 0; i < POOL_N; i++) begin
			pool[i] = $urandom();
			pool[i][7:4] = (i % 3 == 0) ? 4'hF : 4'($urandom_range(0, 3));
		end

		// empty stack cases
		queue_word(MODE_LOOKUP, 32'h0, 32'h0);
		queue_word(MODE_POP, 32'h0, 32'h0);
		queue_word(MODE_ADD, 32'h0, 32'h1234_5678);
		queue_word(MODE_PUSH, 32'h0, 32'h0);
		// extremes, collisions and wrap round
		queue_word(MODE_ADD, 32'h0000_0000, 32'hFFFF_FFFF);
		queue_word(MODE_ADD, 32'hFFFF_FFFF, 32'h0000_0000);
		queue_word(MODE_ADD, 32'h0000_0000, 32'h0000_0005);
		queue_word(MODE_ADD, 32'h1000_0000, 32'h5A5A_5A5A);
		queue_word(MODE_ADD, 32'h7FFF_FFF0, 32'h8000_0001);
		queue_word(MODE_LOOKUP, 32'h0000_0000, 32'h0);
		queue_word(MODE_LOOKUP, 32'hFFFF_FFFF, 32'h0);
		queue_word(MODE_LOOKUP, 32'h7FFF_FFF0, 32'h0);
		queue_word(MODE_LOOKUP, 32'h2000_0000, 32'h0);
		// inner scope shadows outer
		queue_word(MODE_PUSH, 32'h0, 32'h0);
		queue_word(MODE_ADD, 32'h0000_0000, 32'hA5A5_A5A5);
		queue_word(MODE_LOOKUP, 32'h0000_0000, 32'h0);
		queue_word(MODE_LOOKUP, 32'h1000_0000, 32'h0);
		queue_word(MODE_POP, 32'h0, 32'h0);
		queue_word(MODE_LOOKUP, 32'h0000_0000, 32'h0);
		// run the stack to its full depth and past it
		for (int i = 0; i < SCOPE_N - 1; i++) queue_word(MODE_PUSH, 32'h0, 32'h0);
		queue_word(MODE_PUSH, 32'h0, 32'h0);
		queue_word(MODE_LOOKUP, 32'hFFFF_FFFF, 32'h0);

		target = pending_req.size() + RAND_N;
		first = 1'b1;
		while (pending_req.size() < target) begin
			pick = first ? 7 : int'($urandom_range(0, 9));
			first = 1'b0;
			if (pick <= 1) begin
				queue_word(mode_t'($urandom_range(0, 3)), $urandom(), $urandom());
			end else if (pick <= 4) begin
				n = $urandom_range(1, 8);
				for (int i = 0; i < n; i++) begin
					k = pool[$urandom_range(0, POOL_N - 1)];
					if ($urandom_range(0, 1)) begin
						queue_word(MODE_ADD, k, $urandom());
					end else begin
						if ($urandom_range(0, 3) == 0) begin
							k = $urandom();
							k[7:6] = 2'b00;
						end
						queue_word(MODE_LOOKUP, k, $urandom());
					end
				end
			end else if (pick <= 6) begin
				if (gen_depth == SCOPE_N) queue_word(MODE_POP, $urandom(), $urandom());
				queue_word(MODE_PUSH, $urandom(), $urandom());
				n = $urandom_range(1, 6);
				for (int i = 0; i < n; i++)
					queue_word(MODE_ADD, pool[$urandom_range(0, POOL_N - 1)], $urandom());
				n = $urandom_range(1, 6);
				for (int i = 0; i < n; i++)
					queue_word(MODE_LOOKUP, pool[$urandom_range(0, POOL_N - 1)], $urandom());
				if ($urandom_range(0, 1)) queue_word(MODE_POP, $urandom(), $urandom());
			end else if (pick == 7) begin
				// fill one scope until it overflows
				if (gen_depth == SCOPE_N) queue_word(MODE_POP, $urandom(), $urandom());
				queue_word(MODE_PUSH, $urandom(), $urandom());
				base = $urandom_range(0, POOL_N - 1);
				for (int i = 0; i < SLOT_N + 2; i++)
					queue_word(MODE_ADD, pool[(base + i) % POOL_N], $urandom());
				queue_word(MODE_ADD, pool[base], $urandom());
				queue_word(MODE_LOOKUP, pool[(base + SLOT_N + 1) % POOL_N], $urandom());
				queue_word(MODE_LOOKUP, pool[(base + 3) % POOL_N], $urandom());
				queue_word(MODE_LOOKUP, $urandom(), $urandom());
				queue_word(MODE_POP, $urandom(), $urandom());
			end else begin
				n = $urandom_range(1, 3);
				for (int i = 0; i < n; i++) queue_word(MODE_POP, $urandom(), $urandom());
			end
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_req.size() != 0 || req_valid) @(posedge clk);
		while (expected_rsp.size() != 0) @(posedge clk);
		repeat (TAIL_WAIT) @(posedge clk);
		if (mismatches == 0 && expected_rsp.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
